// File: rtl/bepm_pkg.sv
// Package for the binned event pool manager: item structs, request codes,
// controller/datapath command and status structs, register indexes and reset values.
// No dependencies.
`default_nettype none

package bepm_pkg;

  typedef enum logic [1:0] {
    REQ_SELECT          = 2'd0,
    REQ_CLASSIFY_INSERT = 2'd1,
    REQ_INSERT          = 2'd2,
    REQ_READ            = 2'd3
  } req_t;

  localparam logic CFG_VZ_LOW    = 1'b0;
  localparam logic CFG_BIN_SCALE = 1'b1;

  localparam logic signed [15:0] VZ_LOW_RST    = -16'sd17920;
  localparam logic [15:0]        BIN_SCALE_RST = 16'd7490;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         cent;
    logic signed [15:0] vz;
    logic [31:0]        event_tag;
    logic [3:0]         entry_index;
    logic [3:0]         random_slot;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] tag_out;
    logic [4:0]  pool_size;
    logic [7:0]  event_class;
    logic [3:0]  slot;
    logic        replaced;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic cls;
    logic rdc;
    logic exec;
    logic trd;
    logic clr;
    logic load;
  } bepm_cmd_t;

  typedef struct packed {
    logic req_read;
    logic read_hit;
    logic clr_done;
  } bepm_sts_t;

endpackage

`default_nettype wire

// File: rtl/bepm_ctrl.sv
// Controller of the binned event pool manager: sequencing FSM and result-valid flag.
// Depends on bepm_pkg.
`default_nettype none

module bepm_ctrl
  import bepm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_req,
  input  wire logic       out_ready,
  input  wire bepm_sts_t  sts,
  output logic            in_ready,
  output logic            out_valid,
  output bepm_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CLS,
    ST_RDC,
    ST_EXEC,
    ST_TRD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;
  req_t   req_in;

  assign req_in   = req_t'(in_req);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_ready && in_valid;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.mul     = (state_r == ST_MUL);
    cmd.cls     = (state_r == ST_CLS);
    cmd.rdc     = (state_r == ST_RDC);
    cmd.exec    = (state_r == ST_EXEC);
    cmd.trd     = (state_r == ST_TRD);
    cmd.clr     = (state_r == ST_CLEAR);
    cmd.load    = ((state_r == ST_EXEC) && !(sts.req_read && sts.read_hit)) ||
                  (state_r == ST_TRD);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req_in == REQ_SELECT || req_in == REQ_CLASSIFY_INSERT) state_nxt = ST_MUL;
          else state_nxt = ST_RDC;
        end
      end
      ST_MUL:  state_nxt = ST_CLS;
      ST_CLS:  state_nxt = ST_RDC;
      ST_RDC:  if (out_free) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (sts.req_read && sts.read_hit) ? ST_TRD : ST_IDLE;
      ST_TRD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bepm_dpath.sv
// Datapath of the binned event pool manager: config registers, vertex binning,
// pool count memory, tag memory and result register. Depends on bepm_pkg.
`default_nettype none

module bepm_dpath
  import bepm_pkg::*;
#(
  parameter int VERTEX_BINS = 16,
  parameter int CENT_BINS   = 16,
  parameter int POOL_DEPTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire in_item_t    in_data,
  input  wire bepm_cmd_t   cmd,
  output bepm_sts_t        sts,
  output out_item_t        out_data
);

  localparam int NUM_CLASSES = VERTEX_BINS * CENT_BINS;
  localparam int TAG_DEPTH   = NUM_CLASSES * POOL_DEPTH;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int TADDR_W = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int CMP_W   = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CLS_W-1:0]   CLS_RST   = CLS_W'((VERTEX_BINS / 2) * CENT_BINS);
  localparam logic [CLS_W-1:0]   CLS_LAST  = CLS_W'(NUM_CLASSES - 1);
  localparam logic [CLS_W-1:0]   CB_K      = CLS_W'(CENT_BINS);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(POOL_DEPTH);
  localparam logic [TADDR_W-1:0] DEPTH_K   = TADDR_W'(POOL_DEPTH);
  localparam logic [7:0]         VB_LIM    = 8'(VERTEX_BINS);
  localparam logic [7:0]         VB_LAST   = 8'(VERTEX_BINS - 1);
  localparam logic [6:0]         CB_LIM    = 7'(CENT_BINS);
  localparam logic [6:0]         CB_LAST   = 7'(CENT_BINS - 1);

  // configuration
  logic signed [15:0] vz_low_r;
  logic [15:0]        bin_scale_r;

  // captured item
  logic [1:0]  req_r;
  logic [3:0]  cent_r;
  logic [31:0] tag_r;
  logic [3:0]  idx_r;
  logic [3:0]  rnd_r;
  logic [15:0] diff_r;
  logic [31:0] prod_r;

  // pool state
  logic [CLS_W-1:0]  cur_cls_r;
  logic [SLOT_W-1:0] last_slot_r;
  logic [CLS_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]  cnt_mem [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_rd_r;
  logic [31:0]       tag_mem [TAG_DEPTH];
  logic [31:0]       tag_rd_r;
  out_item_t         out_r, out_nxt;

  // combinational
  logic signed [16:0] diff_full;
  logic [7:0]         vbin_raw, vbin;
  logic [6:0]         cbin;
  logic [CLS_W-1:0]   cls_nxt;
  logic [SLOT_W-1:0]  rnd_tbl [16];
  logic               is_insert, is_read, full, hit;
  logic [SLOT_W-1:0]  ins_slot;
  logic [CNT_W-1:0]   cnt_inc;
  logic               cnt_we;
  logic [CLS_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [TADDR_W-1:0] tag_addr;
  logic               tag_we;

  // replacement slot: random value modulo pool depth, as a constant table
  for (genvar gi = 0; gi < 16; gi++) begin : g_rnd
    assign rnd_tbl[gi] = SLOT_W'(gi % POOL_DEPTH);
  end

  // vertex offset; floored at zero when it is captured
  assign diff_full = 17'(in_data.vz) - 17'(vz_low_r);

  // class from the registered product
  assign vbin_raw = prod_r[31:24];
  assign vbin     = (vbin_raw >= VB_LIM) ? VB_LAST : vbin_raw;
  assign cbin     = ({3'b000, cent_r} >= CB_LIM) ? CB_LAST : {3'b000, cent_r};
  assign cls_nxt  = CLS_W'(vbin) * CB_K + CLS_W'(cbin);

  assign is_insert = (req_r == REQ_INSERT) || (req_r == REQ_CLASSIFY_INSERT);
  assign is_read   = (req_r == REQ_READ);
  assign full      = (cnt_rd_r >= CNT_FULL);
  assign hit       = CMP_W'(idx_r) < CMP_W'(cnt_rd_r);
  assign ins_slot  = full ? rnd_tbl[rnd_r] : SLOT_W'(cnt_rd_r);
  assign cnt_inc   = cnt_rd_r + CNT_W'(1);

  assign cnt_we    = cmd.clr || (cmd.exec && is_insert && !full);
  assign cnt_waddr = cmd.clr ? clr_cnt_r : cur_cls_r;
  assign cnt_wdata = cmd.clr ? '0 : cnt_inc;

  assign tag_addr = TADDR_W'(cur_cls_r) * DEPTH_K +
                    (is_read ? TADDR_W'(SLOT_W'(idx_r)) : TADDR_W'(ins_slot));
  assign tag_we   = cmd.exec && is_insert;

  assign sts.req_read = is_read;
  assign sts.read_hit = hit;
  assign sts.clr_done = (clr_cnt_r == CLS_LAST);

  always_comb begin
    out_nxt             = '0;
    out_nxt.event_class = 8'(cur_cls_r);
    if (cmd.trd) begin
      out_nxt.valid_res = 1'b1;
      out_nxt.tag_out   = tag_rd_r;
      out_nxt.pool_size = 5'(cnt_rd_r);
      out_nxt.slot      = 4'(last_slot_r);
    end else if (is_insert) begin
      out_nxt.valid_res = 1'b1;
      out_nxt.pool_size = full ? 5'(cnt_rd_r) : 5'(cnt_inc);
      out_nxt.slot      = 4'(ins_slot);
      out_nxt.replaced  = full;
    end else begin
      // select succeeds; a read that lands here missed
      out_nxt.valid_res = !is_read;
      out_nxt.pool_size = 5'(cnt_rd_r);
      out_nxt.slot      = 4'(last_slot_r);
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vz_low_r    <= VZ_LOW_RST;
      bin_scale_r <= BIN_SCALE_RST;
      cur_cls_r   <= CLS_RST;
      last_slot_r <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VZ_LOW:    vz_low_r    <= cfg_wdata;
          CFG_BIN_SCALE: bin_scale_r <= cfg_wdata;
          default:       bin_scale_r <= bin_scale_r;
        endcase
      end
      if (cmd.cls) cur_cls_r <= cls_nxt;
      if (tag_we) last_slot_r <= ins_slot;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + CLS_W'(1);
    end
  end

  // item capture, multiply stage and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_data.req_type;
      cent_r <= in_data.cent;
      tag_r  <= in_data.event_tag;
      idx_r  <= in_data.entry_index;
      rnd_r  <= in_data.random_slot;
      diff_r <= (diff_full > 17'sd0) ? diff_full[15:0] : 16'd0;
    end
    if (cmd.mul) prod_r <= diff_r * bin_scale_r;
    if (cmd.load) out_r <= out_nxt;
  end

  // pool count memory
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.rdc) cnt_rd_r <= cnt_mem[cur_cls_r];
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_addr] <= tag_r;
    if (cmd.exec) tag_rd_r <= tag_mem[tag_addr];
  end

endmodule

`default_nettype wire

// File: rtl/binned_event_pool_manager.sv
// Select and classify-insert pass through the multiply, classify, count read and execute
// states; insert and a read go straight to count read and execute, and a read hit adds
// a tag read state. Items are handled one at a time; the next item can be taken the cycle
// after the result is loaded, and the count read state waits while a result is pending.
// Reset (rst_n, synchronous) starts a clearing pass over the pool counts of every
// class, during which no item is taken.
`default_nettype none

module binned_event_pool_manager
  import bepm_pkg::*;
#(
  parameter int VERTEX_BINS = 16,
  parameter int CENT_BINS   = 16,
  parameter int POOL_DEPTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: index 0 vz_low, index 1 bin_scale
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // request items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  bepm_cmd_t ctl_cmd;
  bepm_sts_t ctl_sts;

  // Sequence each item: capture, optional classify (multiply then bin), read the
  // pool count, update or look up, and hold the result until it is taken.
  bepm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_data.req_type),
    .out_ready (out_ready),
    .sts       (ctl_sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (ctl_cmd)
  );

  // Hold config, the class and slot registers, both memories and the result item.
  bepm_dpath #(
    .VERTEX_BINS (VERTEX_BINS),
    .CENT_BINS   (CENT_BINS),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending item");

  // no new item while one is in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(ctl_cmd.mul || ctl_cmd.cls || ctl_cmd.rdc || ctl_cmd.exec || ctl_cmd.trd))
    else $error("item accepted while another is in work");

  // tag read result follows its lookup cycle
  a_trd_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.trd |-> $past(ctl_cmd.exec))
    else $error("tag result without lookup");

  // hold off items during the count clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.clr |-> !in_ready)
    else $error("item taken during clearing pass");
`endif

endmodule

`default_nettype wire
